// ===== rtl/afd_pkg.sv =====
// package for the api frame deframer
// sequencer states and framing constants, no dependencies
package afd_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LEN,
    S_CHK,
    S_SUM,
    S_WORD,
    S_OUT
  } state_e;

  localparam logic [7:0] START_BYTE    = 8'h7e;
  localparam logic [7:0] CKSUM_BASE    = 8'hff;
  localparam int         MIN_HELD      = 5;
  localparam int         MAX_RESULTS   = 64;
  localparam logic [6:0] RESET_MAX_LEN = 7'd115;

endpackage

// ===== rtl/afd_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module afd_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/api_frame_resync_deframer_top.sv =====
// api frame deframer top level: circular byte buffer and scan sequencer
// depends on afd_pkg and afd_ram
// each buffer read has an address phase and a registered data phase; a byte that
//   completes no frame is dropped after the scan, length or checksum check
// a frame gets a checksum pass, then its payload bytes are read into result words
//   presented one at a time; rx_stall_o is high until the whole rescan ends
// the sequencer reads one byte at a time through the single buffer read port
// reset empties the buffer and loads max_frame_len with 115; no clearing pass
module api_frame_resync_deframer_top #(
  parameter int BUF_BYTES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  api_type_o,
  output logic [15:0] src_addr_o,
  output logic [7:0]  tx_frame_id_o,
  output logic [7:0]  delivery_status_o,
  output logic [7:0]  rssi_o,
  output logic [7:0]  rx_options_o,
  output logic [6:0]  payload_len_o,
  output logic [63:0] data_word_o,
  output logic [3:0]  word_bytes_o,
  output logic        last_o
);
  import afd_pkg::*;

  localparam int AW = $clog2(BUF_BYTES);
  localparam int CW = $clog2(BUF_BYTES + 1);
  localparam int IW = (CW > 8) ? CW : 8;
  localparam logic [IW:0] BufLen = (IW+1)'(BUF_BYTES);

  state_e        state_q, state_d;
  logic          ph_q, ph_d;
  logic [AW-1:0] head_q, head_d;
  logic [IW-1:0] fill_q, fill_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [15:0]   flen_q, flen_d;
  logic [7:0]    sum_q, sum_d;
  logic [7:0]    hdr_q [5];
  logic [7:0]    hdr_d [5];
  logic [63:0]   word_q, word_d;
  logic [3:0]    k_q, k_d;
  logic [6:0]    rem_q, rem_d;
  logic [6:0]    cnt_q, cnt_d;
  logic [6:0]    maxlen_q;

  logic [IW-1:0] adv;
  logic [IW:0]   hsum, rsum, wsum;
  logic [AW-1:0] head_adv, raddr, waddr;
  logic          we;
  logic [7:0]    rdata;
  logic [7:0]    pkt;
  logic [6:0]    n_len;
  logic [7:0]    words;
  logic          rx_acc;
  logic [2:0]    hsel;

  afd_ram #(.Width(8), .Depth(BUF_BYTES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (rx_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign rx_stall_o  = (state_q != S_IDLE);
  assign rx_acc      = rx_valid_i && (state_q == S_IDLE);
  assign we          = rx_acc;

  always_comb begin
    hsum = {{(IW+1-AW){1'b0}}, head_q} + {1'b0, adv};
    if (hsum >= BufLen) hsum = hsum - BufLen;
    head_adv = hsum[AW-1:0];
    rsum = {{(IW+1-AW){1'b0}}, head_q} + {1'b0, idx_d};
    if (rsum >= BufLen) rsum = rsum - BufLen;
    raddr = rsum[AW-1:0];
    wsum = {{(IW+1-AW){1'b0}}, head_q} + {1'b0, fill_q};
    if (wsum >= BufLen) wsum = wsum - BufLen;
    waddr = (fill_q == IW'(BUF_BYTES)) ? head_q : wsum[AW-1:0];
  end

  assign pkt   = {1'b0, flen_q[6:0]} + 8'd4;
  assign n_len = (flen_q[6:0] >= 7'(MIN_HELD)) ? (flen_q[6:0] - 7'(MIN_HELD)) : 7'd0;
  assign words = (n_len == 7'd0) ? 8'd1 : 8'(({1'b0, n_len} + 8'd7) >> 3);
  assign hsel  = idx_q[2:0] - 3'd3;

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    head_d  = head_q;
    fill_d  = fill_q;
    idx_d   = idx_q;
    flen_d  = flen_q;
    sum_d   = sum_q;
    hdr_d   = hdr_q;
    word_d  = word_q;
    k_d     = k_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    adv     = IW'(1);
    case (state_q)
      S_IDLE: begin
        if (rx_valid_i) begin
          if (fill_q == IW'(BUF_BYTES)) begin
            head_d = head_adv;
          end else begin
            fill_d = fill_q + IW'(1);
          end
          cnt_d   = '0;
          idx_d   = '0;
          ph_d    = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        idx_d = '0;
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (rdata != START_BYTE) begin
            head_d = head_adv;
            fill_d = fill_q - IW'(1);
            if (fill_q == IW'(1)) state_d = S_IDLE;
          end else if (fill_q < IW'(MIN_HELD)) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = IW'(1);
            state_d = S_LEN;
          end
        end
      end
      S_LEN: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (idx_q == IW'(1)) begin
            flen_d[15:8] = rdata;
            idx_d        = IW'(2);
          end else begin
            flen_d[7:0] = rdata;
            state_d     = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (flen_q > {9'd0, maxlen_q}) begin
          head_d  = head_adv;
          fill_d  = fill_q - IW'(1);
          idx_d   = '0;
          state_d = S_SCAN;
        end else if ({{(IW-8){1'b0}}, pkt} > fill_q) begin
          state_d = S_IDLE;
        end else begin
          idx_d = IW'(3);
          sum_d = '0;
          for (int j = 0; j < 5; j++) hdr_d[j] = '0;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (idx_q == {{(IW-8){1'b0}}, pkt - 8'd1}) begin
            if (rdata != (CKSUM_BASE - sum_q)) begin
              head_d  = head_adv;
              fill_d  = fill_q - IW'(1);
              idx_d   = '0;
              state_d = S_SCAN;
            end else if ({1'b0, cnt_q} + words > 8'(MAX_RESULTS)) begin
              state_d = S_IDLE;
            end else begin
              idx_d   = IW'(8);
              k_d     = '0;
              rem_d   = n_len;
              word_d  = '0;
              state_d = S_WORD;
            end
          end else begin
            sum_d = sum_q + rdata;
            if (idx_q < IW'(8)) hdr_d[hsel] = rdata;
            idx_d = idx_q + IW'(1);
          end
        end
      end
      S_WORD: begin
        if (!ph_q) begin
          if (rem_q == 7'd0 || k_q == 4'd8) begin
            state_d = S_OUT;
          end else begin
            ph_d = 1'b1;
          end
        end else begin
          ph_d = 1'b0;
          word_d[{k_q[2:0], 3'b000} +: 8] = rdata;
          k_d   = k_q + 4'd1;
          rem_d = rem_q - 7'd1;
          idx_d = idx_q + IW'(1);
        end
      end
      S_OUT: begin
        adv = {{(IW-8){1'b0}}, pkt};
        if (!out_stall_i) begin
          cnt_d = cnt_q + 7'd1;
          if (rem_q == 7'd0) begin
            head_d  = head_adv;
            fill_d  = fill_q - {{(IW-8){1'b0}}, pkt};
            idx_d   = '0;
            if (fill_q == {{(IW-8){1'b0}}, pkt}) begin
              state_d = S_IDLE;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            k_d     = '0;
            word_d  = '0;
            state_d = S_WORD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ph_q     <= 1'b0;
      head_q   <= '0;
      fill_q   <= '0;
      idx_q    <= '0;
      cnt_q    <= '0;
      maxlen_q <= RESET_MAX_LEN;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      head_q  <= head_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) maxlen_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    flen_q <= flen_d;
    sum_q  <= sum_d;
    hdr_q  <= hdr_d;
    word_q <= word_d;
    k_q    <= k_d;
    rem_q  <= rem_d;
  end

  assign out_valid_o       = (state_q == S_OUT);
  assign api_type_o        = hdr_q[0];
  assign src_addr_o        = {hdr_q[1], hdr_q[2]};
  assign tx_frame_id_o     = hdr_q[1];
  assign delivery_status_o = hdr_q[2];
  assign rssi_o            = hdr_q[3];
  assign rx_options_o      = hdr_q[4];
  assign payload_len_o     = n_len;
  assign data_word_o       = word_q;
  assign word_bytes_o      = k_q;
  assign last_o            = (rem_q == 7'd0);

endmodule
